### hw/rtl/dwm_pkg.sv
// ----------------------------------------------------------------------------
// dwm_pkg
// Shared types, codes and constants of the decimal word machine.
// ----------------------------------------------------------------------------
package dwm_pkg;

    localparam int DEF_MEM_WORDS   = 100;
    localparam int DEF_BLOCK_WORDS = 10;

    localparam int WORD_W   = 32;
    localparam int ADDR_W   = 7;
    localparam int FUNC_W   = 2;
    localparam int COUNT_W  = 3;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 4;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;

    localparam logic [WORD_W-1:0] REG_RESET = 32'h2323_2323;
    localparam logic [ADDR_W-1:0] LAST_COUNTER = 7'd99;
    localparam logic [ADDR_W-1:0] DEC_BASE = 7'd10;

    localparam logic [CHAR_W-1:0] CH_G = 8'h47;
    localparam logic [CHAR_W-1:0] CH_P = 8'h50;
    localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_S = 8'h53;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_B = 8'h42;
    localparam logic [CHAR_W-1:0] CH_D = 8'h44;
    localparam logic [CHAR_W-1:0] CH_R = 8'h52;
    localparam logic [CHAR_W-1:0] CH_T = 8'h54;
    localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9 = 8'h39;

    localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_WAIT     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_OUTPUT   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_HALTED   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] STS_BAD      = 3'd5;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD = 2'd0,
        FN_EXEC = 2'd1,
        FN_DATA = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        OP_GD,
        OP_PD,
        OP_LR,
        OP_SR,
        OP_CR,
        OP_BT,
        OP_HALT
    } t_op;

    typedef enum logic [2:0] {
        RESP_DONE,
        RESP_WAIT,
        RESP_ADV,
        RESP_HALT,
        RESP_BAD,
        RESP_PD
    } t_resp;

    typedef enum logic [1:0] {
        RD_FETCH,
        RD_OPER,
        RD_DATA,
        RD_PD
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_LOAD,
        WR_STORE,
        WR_DATA
    } t_wr_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DECODE,
        ST_EXEC,
        ST_OPER,
        ST_MERGE,
        ST_PD_RD,
        ST_PD_WAIT,
        ST_REPLY,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    ir_load;
        logic    reg_load;
        logic    flag_load;
        logic    advance;
        logic    branch;
        logic    gd_start;
        logic    data_step;
        logic    halt;
        logic    k_clear;
        logic    k_inc;
        logic    out_load;
        t_resp   resp;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  awaiting;
        t_op   op;
        logic  bad_operand;
        logic  data_last;
        logic  k_last;
    } t_sts;

endpackage

### hw/rtl/decimal_word_machine_step.sv
// ----------------------------------------------------------------------------
// decimal_word_machine_step
// Teaching machine with a word store, a work register, a compare flag and a
// two-digit instruction counter, stepped one item at a time.
// ----------------------------------------------------------------------------
// The block takes one item at a time and answers it before the next is taken.
// A print instruction yields the ten words of its block one by one, because
// the single read port of the word store serves one word per read and each
// word waits in the output register until it is taken. Halt invalidates every
// word of the store.
module decimal_word_machine_step
    import dwm_pkg::*;
#(
    parameter int MEM_WORDS   = DEF_MEM_WORDS,
    parameter int BLOCK_WORDS = DEF_BLOCK_WORDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [WORD_W-1:0]   i_word,
    input  logic [COUNT_W-1:0]  i_byte_count,
    input  logic                i_card_end,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [WORD_W-1:0]   o_out_word,
    output logic                o_last,
    output logic [ADDR_W-1:0]   o_counter_now,
    output logic                o_flag_now
);

    t_cmd cmd;
    t_sts sts;

    dwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dwm_datapath #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_word        (i_word),
        .i_byte_count  (i_byte_count),
        .i_card_end    (i_card_end),
        .o_status      (o_status),
        .o_out_word    (o_out_word),
        .o_last        (o_last),
        .o_counter_now (o_counter_now),
        .o_flag_now    (o_flag_now)
    );

endmodule

### hw/rtl/dwm_ctrl.sv
// ----------------------------------------------------------------------------
// dwm_ctrl
// Sequencer of the machine: accepts one item, steps the datapath through
// fetch, decode, execute, data merge and reply, and hands each result to the output.
// ----------------------------------------------------------------------------
module dwm_ctrl
    import dwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_resp  r_resp, n_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_resp  <= RESP_DONE;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_sts.func == FN_EXEC && !i_sts.awaiting) begin
                    n_state = ST_DECODE;
                end else if (i_sts.func == FN_DATA && i_sts.awaiting) begin
                    n_state = ST_MERGE;
                end else begin
                    n_state = ST_REPLY;
                end
            end
            ST_DECODE: n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_sts.op == OP_HALT || i_sts.bad_operand) begin
                    n_state = ST_REPLY;
                end else if (i_sts.op == OP_PD) begin
                    n_state = ST_PD_RD;
                end else if (i_sts.op == OP_LR || i_sts.op == OP_CR) begin
                    n_state = ST_OPER;
                end else begin
                    n_state = ST_REPLY;
                end
            end
            ST_OPER:    n_state = ST_REPLY;
            ST_MERGE:   n_state = ST_REPLY;
            ST_PD_RD:   n_state = ST_PD_WAIT;
            ST_PD_WAIT: n_state = ST_RESP;
            ST_REPLY:   n_state = ST_RESP;
            ST_RESP: begin
                if (i_out_ready) begin
                    if (r_resp == RESP_PD && !i_sts.k_last) begin
                        n_state = ST_PD_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.resp  = r_resp;
        n_resp      = r_resp;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            ST_DISPATCH: begin
                n_resp = RESP_DONE;
                case (i_sts.func)
                    FN_LOAD: begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_LOAD;
                    end
                    FN_EXEC: begin
                        if (i_sts.awaiting) begin
                            n_resp = RESP_WAIT;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_FETCH;
                        end
                    end
                    FN_DATA: begin
                        if (i_sts.awaiting) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_DATA;
                        end
                    end
                    default: n_resp = RESP_DONE;
                endcase
            end
            ST_DECODE: o_cmd.ir_load = 1'b1;
            ST_EXEC: begin
                if (i_sts.op == OP_HALT) begin
                    o_cmd.halt = 1'b1;
                    n_resp     = RESP_HALT;
                end else if (i_sts.bad_operand) begin
                    n_resp = RESP_BAD;
                end else begin
                    case (i_sts.op)
                        OP_GD: begin
                            o_cmd.gd_start = 1'b1;
                            n_resp         = RESP_WAIT;
                        end
                        OP_PD: begin
                            o_cmd.advance = 1'b1;
                            o_cmd.k_clear = 1'b1;
                            n_resp        = RESP_PD;
                        end
                        OP_LR, OP_CR: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_OPER;
                            n_resp       = RESP_ADV;
                        end
                        OP_SR: begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = WR_STORE;
                            o_cmd.advance = 1'b1;
                            n_resp        = RESP_ADV;
                        end
                        OP_BT: begin
                            o_cmd.branch = 1'b1;
                            n_resp       = RESP_ADV;
                        end
                        default: n_resp = RESP_HALT;
                    endcase
                end
            end
            ST_OPER: begin
                o_cmd.reg_load  = (i_sts.op == OP_LR);
                o_cmd.flag_load = (i_sts.op == OP_CR);
                o_cmd.advance   = 1'b1;
            end
            ST_MERGE: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_sel    = WR_DATA;
                o_cmd.data_step = 1'b1;
                o_cmd.advance   = i_sts.data_last;
                n_resp          = i_sts.data_last ? RESP_ADV : RESP_WAIT;
            end
            ST_PD_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PD;
            end
            ST_PD_WAIT: o_cmd.out_load = 1'b1;
            ST_REPLY:   o_cmd.out_load = 1'b1;
            ST_RESP: begin
                o_out_valid = 1'b1;
                o_cmd.k_inc = i_out_ready && (r_resp == RESP_PD) && !i_sts.k_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### hw/rtl/dwm_datapath.sv
// ----------------------------------------------------------------------------
// dwm_datapath
// Word store, work register, flag, counter, data-block pointers, instruction
// decode and the registered result, all driven by the sequencer's commands.
// ----------------------------------------------------------------------------
module dwm_datapath
    import dwm_pkg::*;
#(
    parameter int MEM_WORDS   = DEF_MEM_WORDS,
    parameter int BLOCK_WORDS = DEF_BLOCK_WORDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [WORD_W-1:0]   i_word,
    input  logic [COUNT_W-1:0]  i_byte_count,
    input  logic                i_card_end,
    output logic [STATUS_W-1:0] o_status,
    output logic [WORD_W-1:0]   o_out_word,
    output logic                o_last,
    output logic [ADDR_W-1:0]   o_counter_now,
    output logic                o_flag_now
);

    localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int K_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    logic [FUNC_W-1:0]  r_in_func;
    logic [ADDR_W-1:0]  r_in_addr;
    logic [WORD_W-1:0]  r_in_word;
    logic [COUNT_W-1:0] r_in_count;
    logic               r_in_end;

    logic [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic [WORD_W-1:0] rd_word;

    logic [WORD_W-1:0] r_ir;
    logic [WORD_W-1:0] r_work;
    logic              r_flag;
    logic [ADDR_W-1:0] r_counter;
    logic              r_ovf;
    logic              r_awaiting;
    logic [ADDR_W-1:0] r_block_base;
    logic [FILL_W-1:0] r_fill;
    logic [K_W-1:0]    r_k;

    logic [STATUS_W-1:0] r_out_status;
    logic [WORD_W-1:0]   r_out_word;
    logic                r_out_last;
    logic [ADDR_W-1:0]   r_out_counter;
    logic                r_out_flag;

    logic [CHAR_W-1:0]  c0, c1, d0, d1;
    logic [DIGIT_W-1:0] d0v, d1v;
    logic               digits_ok;
    logic [ADDR_W-1:0]  loc, base;
    t_op                op;
    logic               k_last;
    logic               data_last;
    logic [FILL_W-1:0]  fill_inc;

    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data, byte_mask;
    logic              rd_in_range, wr_in_range;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_func  <= i_func;
            r_in_addr  <= i_address;
            r_in_word  <= i_word;
            r_in_count <= i_byte_count;
            r_in_end   <= i_card_end;
        end
    end

    assign c0  = r_ir[31:24];
    assign c1  = r_ir[23:16];
    assign d0  = r_ir[15:8];
    assign d1  = r_ir[7:0];
    assign d0v = d0[DIGIT_W-1:0];
    assign d1v = d1[DIGIT_W-1:0];
    assign digits_ok = (d0 >= CH_0) && (d0 <= CH_9) && (d1 >= CH_0) && (d1 <= CH_9);
    assign base = ADDR_W'(ADDR_W'(d0v) * DEC_BASE);
    assign loc  = base + ADDR_W'(d1v);

    always_comb begin
        if (c0 == CH_G && c1 == CH_D) begin
            op = OP_GD;
        end else if (c0 == CH_P && c1 == CH_D) begin
            op = OP_PD;
        end else if (c0 == CH_L && c1 == CH_R) begin
            op = OP_LR;
        end else if (c0 == CH_S && c1 == CH_R) begin
            op = OP_SR;
        end else if (c0 == CH_C && c1 == CH_R) begin
            op = OP_CR;
        end else if (c0 == CH_B && c1 == CH_T) begin
            op = OP_BT;
        end else begin
            op = OP_HALT;
        end
    end

    assign k_last    = (r_k == K_W'(BLOCK_WORDS - 1));
    assign fill_inc  = r_fill + FILL_W'(1);
    assign data_last = r_in_end || (fill_inc >= FILL_W'(BLOCK_WORDS));

    assign o_sts.func        = t_func'(r_in_func);
    assign o_sts.awaiting    = r_awaiting;
    assign o_sts.op          = op;
    assign o_sts.bad_operand = !digits_ok || (loc >= ADDR_W'(MEM_WORDS));
    assign o_sts.data_last   = data_last;
    assign o_sts.k_last      = k_last;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FETCH: rd_addr = r_counter;
            RD_OPER:  rd_addr = loc;
            RD_DATA:  rd_addr = r_block_base + ADDR_W'(r_fill);
            RD_PD:    rd_addr = base + ADDR_W'(r_k);
            default:  rd_addr = r_counter;
        endcase
    end

    always_comb begin
        case (r_in_count)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'hFF00_0000;
            3'd2:    byte_mask = 32'hFFFF_0000;
            3'd3:    byte_mask = 32'hFFFF_FF00;
            default: byte_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_LOAD: begin
                wr_addr = r_in_addr;
                wr_data = r_in_word;
            end
            WR_STORE: begin
                wr_addr = loc;
                wr_data = r_work;
            end
            WR_DATA: begin
                wr_addr = r_block_base + ADDR_W'(r_fill);
                wr_data = (rd_word & ~byte_mask) | (r_in_word & byte_mask);
            end
            default: begin
                wr_addr = r_in_addr;
                wr_data = r_in_word;
            end
        endcase
    end

    assign rd_in_range = (rd_addr < ADDR_W'(MEM_WORDS));
    assign wr_in_range = (wr_addr < ADDR_W'(MEM_WORDS));
    assign rd_word     = r_rd_ok ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            r_mem[wr_addr[MEM_AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.halt) begin
                r_vld <= '0;
            end else if (i_cmd.wr_en && wr_in_range) begin
                r_vld[wr_addr[MEM_AW-1:0]] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= rd_in_range && r_vld[rd_addr[MEM_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ir_load) begin
            r_ir <= rd_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work       <= REG_RESET;
            r_flag       <= 1'b0;
            r_counter    <= '0;
            r_ovf        <= 1'b0;
            r_awaiting   <= 1'b0;
            r_block_base <= '0;
            r_fill       <= '0;
            r_k          <= '0;
        end else if (i_cmd.halt) begin
            r_work       <= REG_RESET;
            r_flag       <= 1'b0;
            r_counter    <= '0;
            r_ovf        <= 1'b0;
            r_awaiting   <= 1'b0;
            r_block_base <= '0;
            r_fill       <= '0;
        end else begin
            if (i_cmd.reg_load) begin
                r_work <= rd_word;
            end
            if (i_cmd.flag_load) begin
                r_flag <= (r_work == rd_word);
            end
            if (i_cmd.advance || (i_cmd.branch && !r_flag)) begin
                if (r_counter < LAST_COUNTER) begin
                    r_counter <= r_counter + ADDR_W'(1);
                    r_ovf     <= 1'b0;
                end else begin
                    r_counter <= LAST_COUNTER;
                    r_ovf     <= 1'b1;
                end
            end else if (i_cmd.branch) begin
                r_counter <= loc;
                r_ovf     <= 1'b0;
            end
            if (i_cmd.gd_start) begin
                r_awaiting   <= 1'b1;
                r_block_base <= base;
                r_fill       <= '0;
            end else if (i_cmd.data_step) begin
                if (data_last) begin
                    r_awaiting <= 1'b0;
                    r_fill     <= '0;
                end else begin
                    r_fill <= fill_inc;
                end
            end
            if (i_cmd.k_clear) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_counter <= r_counter;
            r_out_flag    <= r_flag;
            r_out_word    <= '0;
            r_out_last    <= 1'b1;
            case (i_cmd.resp)
                RESP_DONE: r_out_status <= STS_DONE;
                RESP_WAIT: r_out_status <= STS_WAIT;
                RESP_ADV:  r_out_status <= r_ovf ? STS_OVERFLOW : STS_DONE;
                RESP_HALT: r_out_status <= STS_HALTED;
                RESP_BAD:  r_out_status <= STS_BAD;
                RESP_PD: begin
                    r_out_status <= (k_last && r_ovf) ? STS_OVERFLOW : STS_OUTPUT;
                    r_out_word   <= rd_word;
                    r_out_last   <= k_last;
                end
                default: r_out_status <= STS_DONE;
            endcase
        end
    end

    assign o_status      = r_out_status;
    assign o_out_word    = r_out_word;
    assign o_last        = r_out_last;
    assign o_counter_now = r_out_counter;
    assign o_flag_now    = r_out_flag;

endmodule

### tb/decimal_word_machine_step_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_word_machine_step_test
// Self-checking bench for the decimal word machine. A directed sequence walks
// through compare, branch, store, a short data card, a print at the top of the
// counter range, a bad operand and halts. Random episodes then load small
// programs at the current counter and step them, feeding data cards whenever
// the machine waits. Every accepted transfer is predicted and each result is
// compared field by field.
// ----------------------------------------------------------------------------
module decimal_word_machine_step_test;
    import dwm_pkg::*;

    localparam int N_WORDS   = DEF_MEM_WORDS;
    localparam int N_BLOCK   = DEF_BLOCK_WORDS;
    localparam int N_RANDOM  = 150;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 60;

    typedef struct {
        t_func              func;
        logic [ADDR_W-1:0]  address;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] byte_count;
        logic               card_end;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   out_word;
        logic                last;
        logic [ADDR_W-1:0]   counter_now;
        logic                flag_now;
    } t_answer;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func       = '0;
    logic [ADDR_W-1:0]   i_address    = '0;
    logic [WORD_W-1:0]   i_word       = '0;
    logic [COUNT_W-1:0]  i_byte_count = '0;
    logic                i_card_end   = 1'b0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [WORD_W-1:0]   o_out_word;
    logic                o_last;
    logic [ADDR_W-1:0]   o_counter_now;
    logic                o_flag_now;

    t_request request_q[$];
    t_answer  answer_q[$];
    t_request cur_req;

    logic [WORD_W-1:0] word_mem [N_WORDS];
    logic [WORD_W-1:0] acc_reg;
    logic              cmp_flag;
    logic [ADDR_W-1:0] instr_ctr;
    logic              wait_data;
    int                blk_base;
    int                blk_fill;
    bit                halt_seen;

    int n_errors   = 0;
    int cycle_cnt  = 0;
    int n_loads    = 0;
    int n_steps    = 0;
    int n_data     = 0;
    int n_prints   = 0;
    int n_halts    = 0;
    int n_bad      = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int last_loc   = 0;

    decimal_word_machine_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_word        (i_word),
        .i_byte_count  (i_byte_count),
        .i_card_end    (i_card_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_out_word    (o_out_word),
        .o_last        (o_last),
        .o_counter_now (o_counter_now),
        .o_flag_now    (o_flag_now)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_machine();
        for (int i = 0; i < N_WORDS; i++) begin
            word_mem[i] = '0;
        end
        acc_reg   = REG_RESET;
        cmp_flag  = 1'b0;
        instr_ctr = '0;
        wait_data = 1'b0;
        blk_base  = 0;
        blk_fill  = 0;
    endfunction

    function automatic void add_answer(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] w,
                                       logic last);
        t_answer a;
        a.status      = status;
        a.out_word    = w;
        a.last        = last;
        a.counter_now = instr_ctr;
        a.flag_now    = cmp_flag;
        answer_q.push_back(a);
    endfunction

    function automatic logic [STATUS_W-1:0] bump_counter();
        if (instr_ctr < LAST_COUNTER) begin
            instr_ctr = instr_ctr + ADDR_W'(1);
            return STS_DONE;
        end
        instr_ctr = LAST_COUNTER;
        return STS_OVERFLOW;
    endfunction

    function automatic logic [WORD_W-1:0] read_word(int a);
        return (a < N_WORDS) ? word_mem[a] : '0;
    endfunction

    function automatic void run_instruction();
        logic [WORD_W-1:0]   ir;
        logic [CHAR_W-1:0]   c0, c1, d0, d1;
        logic [STATUS_W-1:0] st;
        t_op                 op;
        int                  loc;
        int                  base;

        n_steps++;
        ir = read_word(int'(instr_ctr));
        {c0, c1, d0, d1} = ir;
        if (c0 == CH_G && c1 == CH_D)      op = OP_GD;
        else if (c0 == CH_P && c1 == CH_D) op = OP_PD;
        else if (c0 == CH_L && c1 == CH_R) op = OP_LR;
        else if (c0 == CH_S && c1 == CH_R) op = OP_SR;
        else if (c0 == CH_C && c1 == CH_R) op = OP_CR;
        else if (c0 == CH_B && c1 == CH_T) op = OP_BT;
        else                               op = OP_HALT;

        if (op == OP_HALT) begin
            clear_machine();
            halt_seen = 1'b1;
            n_halts++;
            add_answer(STS_HALTED, '0, 1'b1);
            return;
        end
        if (d0 < CH_0 || d0 > CH_9 || d1 < CH_0 || d1 > CH_9) begin
            n_bad++;
            add_answer(STS_BAD, '0, 1'b1);
            return;
        end
        loc = int'(d0 - CH_0) * int'(DEC_BASE) + int'(d1 - CH_0);
        if (loc >= N_WORDS) begin
            n_bad++;
            add_answer(STS_BAD, '0, 1'b1);
            return;
        end

        case (op)
            OP_GD: begin
                wait_data = 1'b1;
                blk_base  = (loc / int'(DEC_BASE)) * int'(DEC_BASE);
                blk_fill  = 0;
                add_answer(STS_WAIT, '0, 1'b1);
            end
            OP_PD: begin
                base = (loc / int'(DEC_BASE)) * int'(DEC_BASE);
                st = bump_counter();
                for (int k = 0; k < N_BLOCK; k++) begin
                    n_prints++;
                    if (k == N_BLOCK - 1 && st != STS_DONE) begin
                        add_answer(st, read_word(base + k), 1'b1);
                    end else begin
                        add_answer(STS_OUTPUT, read_word(base + k), k == N_BLOCK - 1);
                    end
                end
            end
            OP_LR: begin
                acc_reg = word_mem[loc];
                add_answer(bump_counter(), '0, 1'b1);
            end
            OP_SR: begin
                word_mem[loc] = acc_reg;
                add_answer(bump_counter(), '0, 1'b1);
            end
            OP_CR: begin
                cmp_flag = (acc_reg == word_mem[loc]);
                add_answer(bump_counter(), '0, 1'b1);
            end
            default: begin
                if (cmp_flag) begin
                    instr_ctr = ADDR_W'(loc);
                    add_answer(STS_DONE, '0, 1'b1);
                end else begin
                    add_answer(bump_counter(), '0, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void take_card_word(t_request r);
        logic [WORD_W-1:0] mask;
        int                n;
        int                a;

        n_data++;
        n = (r.byte_count > 3'd4) ? 4 : int'(r.byte_count);
        mask = (n == 0) ? '0 : ({WORD_W{1'b1}} << (CHAR_W * (4 - n)));
        a = blk_base + blk_fill;
        if (a < N_WORDS) begin
            word_mem[a] = (word_mem[a] & ~mask) | (r.word & mask);
        end
        blk_fill++;
        if (r.card_end || blk_fill >= N_BLOCK) begin
            wait_data = 1'b0;
            blk_fill  = 0;
            add_answer(bump_counter(), '0, 1'b1);
        end else begin
            add_answer(STS_WAIT, '0, 1'b1);
        end
    endfunction

    function automatic void machine_step(t_request r);
        case (r.func)
            FN_LOAD: begin
                n_loads++;
                if (int'(r.address) < N_WORDS) begin
                    word_mem[r.address] = r.word;
                end
                add_answer(STS_DONE, '0, 1'b1);
            end
            FN_EXEC: begin
                if (wait_data) begin
                    add_answer(STS_WAIT, '0, 1'b1);
                end else begin
                    run_instruction();
                end
            end
            FN_DATA: begin
                if (wait_data) begin
                    take_card_word(r);
                end else begin
                    add_answer(STS_DONE, '0, 1'b1);
                end
            end
            default: begin
                add_answer(STS_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] encode(t_op op, int loc);
        logic [CHAR_W-1:0] c0, c1;

        case (op)
            OP_GD:   begin c0 = CH_G; c1 = CH_D; end
            OP_PD:   begin c0 = CH_P; c1 = CH_D; end
            OP_LR:   begin c0 = CH_L; c1 = CH_R; end
            OP_SR:   begin c0 = CH_S; c1 = CH_R; end
            OP_CR:   begin c0 = CH_C; c1 = CH_R; end
            OP_BT:   begin c0 = CH_B; c1 = CH_T; end
            default: begin c0 = CH_S + 8'd1; c1 = CH_T; end
        endcase
        return {c0, c1, CH_0 + CHAR_W'(loc / 10), CH_0 + CHAR_W'(loc % 10)};
    endfunction

    function automatic logic [WORD_W-1:0] pick_instr(int pc, int len);
        logic [WORD_W-1:0] w;
        int                loc;

        loc = $urandom_range(0, N_WORDS - 1);
        case ($urandom_range(0, 12))
            0, 1: begin
                last_loc = loc;
                w = encode(OP_LR, loc);
            end
            2:       w = encode(OP_SR, loc);
            3, 4:    w = encode(OP_CR, ($urandom_range(0, 1) == 0) ? last_loc : loc);
            5, 6:    w = encode(OP_BT, $urandom_range(pc, pc + len - 1));
            7, 8:    w = encode(OP_GD, loc);
            9:       w = encode(OP_PD, loc);
            10:      w = encode(OP_HALT, loc);
            11: begin
                w = encode(t_op'($urandom_range(0, 5)), loc);
                if ($urandom_range(0, 1) == 0) w[15:8] = CHAR_W'($urandom);
                else                           w[7:0]  = CHAR_W'($urandom);
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic void push_item(t_func f, int addr, logic [WORD_W-1:0] w, int bc,
                                      bit ce);
        t_request r;
        r.func       = f;
        r.address    = ADDR_W'(addr);
        r.word       = w;
        r.byte_count = COUNT_W'(bc);
        r.card_end   = ce;
        request_q.push_back(r);
    endfunction

    task automatic wait_idle();
        while (request_q.size() != 0 || i_valid) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                machine_step(cur_req);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    i_func       <= cur_req.func;
                    i_address    <= cur_req.address;
                    i_word       <= cur_req.word;
                    i_byte_count <= cur_req.byte_count;
                    i_card_end   <= cur_req.card_end;
                    i_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 7);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Stalls come in short runs, and no new run starts while bits 9:8 of the cycle count are zero.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (cycle_cnt[9:8] != 2'd0 && $urandom_range(0, 4) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [WORD_W-1:0] exp_val,
                                        logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                $error("result transfer with nothing expected: status %0d word 0x%0h",
                       o_status, o_out_word);
                n_errors++;
            end else begin
                a = answer_q.pop_front();
                check_field("status", WORD_W'(a.status), WORD_W'(o_status));
                check_field("out_word", a.out_word, o_out_word);
                check_field("last", WORD_W'(a.last), WORD_W'(o_last));
                check_field("counter_now", WORD_W'(a.counter_now), WORD_W'(o_counter_now));
                check_field("flag_now", WORD_W'(a.flag_now), WORD_W'(o_flag_now));
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
                 answer_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int            n_random;
        int            pc;
        int            len;
        int            steps;
        logic [WORD_W-1:0] w;

        clear_machine();
        halt_seen = 1'b0;

        push_item(FN_LOAD, 127, 32'hA5C3_F00F, 4, 1'b1);
        push_item(FN_NONE, 85, 32'h5A3C_0FF0, 7, 1'b1);
        push_item(FN_DATA, 0, 32'hFFFF_FFFF, 4, 1'b0);
        push_item(FN_LOAD, 50, REG_RESET, 0, 1'b0);
        push_item(FN_LOAD, 0, encode(OP_CR, 50), 0, 1'b0);
        push_item(FN_LOAD, 1, encode(OP_BT, 97), 0, 1'b0);
        push_item(FN_LOAD, 97, encode(OP_SR, 41), 0, 1'b0);
        push_item(FN_LOAD, 98, encode(OP_GD, 93), 0, 1'b0);
        push_item(FN_LOAD, 99, encode(OP_PD, 90), 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_LOAD, 60, encode(OP_LR, 41), 0, 1'b0);
        push_item(FN_DATA, 0, 32'h1234_5678, 0, 1'b0);
        push_item(FN_DATA, 0, 32'hFFFF_FFFF, 7, 1'b0);
        push_item(FN_DATA, 0, 32'h0000_0000, 1, 1'b0);
        push_item(FN_DATA, 0, 32'h4142_4344, 3, 1'b1);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_LOAD, 99, {CH_L, CH_R, CH_9, CH_9 + 8'd1}, 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_LOAD, 99, encode(OP_HALT, 0), 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);
        push_item(FN_EXEC, 0, '0, 0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        n_random = 0;
        while (n_random < N_RANDOM) begin
            wait_idle();
            halt_seen = 1'b0;
            pc = int'(instr_ctr);
            len = $urandom_range(3, 12);
            if (len > N_WORDS - pc) len = N_WORDS - pc;

            repeat ($urandom_range(0, 3)) begin
                w = ($urandom_range(0, 2) == 0) ? acc_reg : $urandom;
                push_item(FN_LOAD, $urandom_range(0, 127), w, 0, 1'b0);
                n_random++;
            end
            for (int i = 0; i < len; i++) begin
                if (i == len - 1 && $urandom_range(0, 2) != 0) w = encode(OP_HALT, 0);
                else                                           w = pick_instr(pc, len);
                push_item(FN_LOAD, pc + i, w, 0, 1'b0);
                n_random++;
            end

            steps = $urandom_range(len, 3 * len);
            for (int s = 0; s < steps && !halt_seen; s++) begin
                wait_idle();
                if (halt_seen) break;
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_item(FN_NONE, $urandom_range(0, 127), $urandom,
                                     $urandom_range(0, 7), $urandom_range(0, 1) == 1);
                        1: push_item(wait_data ? FN_EXEC : FN_DATA, $urandom_range(0, 127),
                                     $urandom, $urandom_range(0, 7),
                                     $urandom_range(0, 1) == 1);
                        default: push_item(FN_LOAD, $urandom_range(N_WORDS, 127), $urandom,
                                           0, 1'b0);
                    endcase
                end else if (wait_data) begin
                    push_item(FN_DATA, $urandom_range(0, 127), $urandom,
                              ($urandom_range(0, 1) == 0) ? 4 : $urandom_range(0, 7),
                              $urandom_range(0, 3) == 0);
                    n_random++;
                end else begin
                    push_item(FN_EXEC, $urandom_range(0, 127), $urandom, 0, 1'b0);
                    n_random++;
                end
            end
        end

        wait_idle();
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Covered %0d loads, %0d instruction steps and %0d data card words,",
                 n_loads, n_steps, n_data);
        $display("with %0d printed words, %0d halts and %0d bad operands.",
                 n_prints, n_halts, n_bad);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
